### src/tprc_pkg.sv
`default_nettype none
package tprc_pkg;

  // default table depth, one entry per tcp port
  localparam int unsigned PORT_ENTRIES_DEF = 65536;

  // configuration register indexes
  localparam logic [1:0] CFG_LISTEN_PORT    = 2'd0;
  localparam logic [1:0] CFG_LISTEN_ADDR_HI = 2'd1;
  localparam logic [1:0] CFG_LISTEN_ADDR_LO = 2'd2;

  // connection state codes
  localparam logic [2:0] CS_CLOSED = 3'd0;
  localparam logic [2:0] CS_SYN    = 3'd1;
  localparam logic [2:0] CS_SYNACK = 3'd2;
  localparam logic [2:0] CS_OPEN   = 3'd3;
  localparam logic [2:0] CS_WAIT   = 3'd4;

  localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_EVAL
  } tprc_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic cap;
    logic quot;
    logic rem;
    logic ev;
  } tprc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
  } tprc_stat_t;

endpackage
`default_nettype wire

### src/tprc_ram.sv
`default_nettype none
module tprc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/tprc_ctrl.sv
`default_nettype none
module tprc_ctrl
  import tprc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire tprc_stat_t stat,
  output logic            busy,
  output tprc_cmd_t       cmd
);

  tprc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd.quot  = 1'b1;
        state_nxt = ST_REM;
      end
      ST_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.ev    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### src/tprc_dp.sv
`default_nettype none
module tprc_dp
  import tprc_pkg::*;
#(
  parameter int unsigned PORT_ENTRIES = PORT_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tprc_cmd_t   cmd,
  output tprc_stat_t       stat,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_outbound,
  input  wire logic        in_is_ipv6,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic        in_flag_syn,
  input  wire logic        in_flag_ack,
  input  wire logic        in_flag_fin,
  input  wire logic        in_flag_rst,
  input  wire logic [63:0] in_src_addr_hi,
  input  wire logic [63:0] in_src_addr_lo,
  input  wire logic [63:0] in_dst_addr_hi,
  input  wire logic [63:0] in_dst_addr_lo,
  output logic             out_valid,
  output logic             out_forward,
  output logic [2:0]       out_new_state,
  output logic [15:0]      out_src_port,
  output logic [15:0]      out_dst_port,
  output logic [63:0]      out_src_addr_hi,
  output logic [63:0]      out_src_addr_lo,
  output logic [63:0]      out_dst_addr_hi,
  output logic [63:0]      out_dst_addr_lo
);

  localparam int unsigned IW = $clog2(PORT_ENTRIES);
  localparam int unsigned DW = 16 + 4 * 64;
  // reciprocal for the index reduction, exact for 16-bit keys
  localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(PORT_ENTRIES) - 64'd1)
                                      / 64'(PORT_ENTRIES));
  localparam logic [16:0] NMOD  = 17'(PORT_ENTRIES);
  localparam logic [IW-1:0] CLR_LAST = IW'(PORT_ENTRIES - 1);

  // configuration registers
  logic [15:0] listen_port_r;
  logic [63:0] listen_addr_hi_r, listen_addr_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_port_r    <= 16'd1;
      listen_addr_hi_r <= '0;
      listen_addr_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LISTEN_PORT:    listen_port_r    <= cfg_wdata[15:0];
        CFG_LISTEN_ADDR_HI: listen_addr_hi_r <= cfg_wdata;
        CFG_LISTEN_ADDR_LO: listen_addr_lo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clearing sweep counter
  logic [IW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clr_last = (clr_cnt_r == CLR_LAST);

  // captured transaction
  logic        outb_r, v6_r, local_r, syn_r, ack_r, finrst_r;
  logic [15:0] sport_r, dport_r, key_r;
  logic [63:0] shi_r, slo_r, dhi_r, dlo_r;
  logic        local_in;

  assign local_in = (in_src_port != listen_port_r);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      outb_r   <= in_outbound;
      v6_r     <= in_is_ipv6;
      local_r  <= local_in;
      syn_r    <= in_flag_syn;
      ack_r    <= in_flag_ack;
      finrst_r <= in_flag_fin | in_flag_rst;
      sport_r  <= in_src_port;
      dport_r  <= in_dst_port;
      key_r    <= local_in ? in_src_port : in_dst_port;
      shi_r    <= in_is_ipv6 ? in_src_addr_hi : '0;
      slo_r    <= in_is_ipv6 ? in_src_addr_lo : {32'd0, in_src_addr_lo[31:0]};
      dhi_r    <= in_is_ipv6 ? in_dst_addr_hi : '0;
      dlo_r    <= in_is_ipv6 ? in_dst_addr_lo : {32'd0, in_dst_addr_lo[31:0]};
    end
  end

  // index reduction: quotient by reciprocal, then remainder
  logic [48:0]   prod;
  logic [15:0]   quot_r;
  logic [32:0]   qn;
  logic [32:0]   rem_full;
  logic [IW-1:0] rem;
  logic [IW-1:0] idx_r;

  assign prod     = 49'(key_r) * 49'(RECIP);
  assign qn       = 33'(quot_r) * 33'(NMOD);
  assign rem_full = 33'(key_r) - qn;
  assign rem      = rem_full[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.quot) begin
      quot_r <= prod[47:32];
    end
    if (cmd.rem) begin
      idx_r <= rem;
    end
  end

  // table memories
  logic          st_we, dat_we;
  logic [IW-1:0] st_waddr;
  logic [3:0]    st_wdata, st_rdata;
  logic [DW-1:0] dat_wdata, dat_rdata;

  tprc_ram #(.WIDTH(4), .DEPTH(PORT_ENTRIES)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rem),
    .rdata (st_rdata)
  );

  tprc_ram #(.WIDTH(DW), .DEPTH(PORT_ENTRIES)) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (idx_r),
    .wdata (dat_wdata),
    .raddr (rem),
    .rdata (dat_rdata)
  );

  // handshake state transition
  logic [2:0] cur, nxt;
  logic       rec, fwd, chg;

  assign cur = st_rdata[2:0];
  assign rec = st_rdata[3];

  always_comb begin
    nxt = cur;
    fwd = 1'b1;
    if (local_r) begin
      unique case (cur)
        CS_SYN:    if (finrst_r) nxt = CS_WAIT; else fwd = 1'b0;
        CS_SYNACK: begin
          if (finrst_r) nxt = CS_WAIT;
          else if (ack_r) nxt = CS_OPEN;
          else fwd = 1'b0;
        end
        CS_OPEN:   if (finrst_r) nxt = CS_WAIT;
        CS_WAIT:   if (ack_r) nxt = CS_CLOSED; else fwd = 1'b0;
        default:   if (syn_r) nxt = CS_SYN; else fwd = 1'b0;
      endcase
    end else begin
      unique case (cur)
        CS_SYN: begin
          if (finrst_r) nxt = CS_WAIT;
          else if (syn_r && ack_r) nxt = CS_SYNACK;
          else fwd = 1'b0;
        end
        CS_SYNACK: begin
          if (finrst_r) nxt = CS_WAIT;
          else if (!ack_r) fwd = 1'b0;
        end
        CS_OPEN:   if (finrst_r) nxt = CS_WAIT;
        CS_WAIT:   if (ack_r) nxt = CS_CLOSED; else fwd = 1'b0;
        default:   fwd = 1'b0;
      endcase
    end
  end

  assign chg = cmd.ev && outb_r && fwd && (nxt != cur);

  // table write-back, or the clearing sweep
  assign st_we     = cmd.clr || chg;
  assign st_waddr  = cmd.clr ? clr_cnt_r : idx_r;
  assign st_wdata  = cmd.clr ? {1'b0, CS_CLOSED} : {rec | local_r, nxt};
  assign dat_we    = chg && local_r && !rec;
  assign dat_wdata = {dport_r, shi_r, slo_r, dhi_r, dlo_r};

  // restored header words from the table
  logic [15:0] o_dport;
  logic [63:0] o_shi, o_slo, o_dhi, o_dlo;
  logic [63:0] rst_slo, rst_dlo, lis_lo;

  assign {o_dport, o_shi, o_slo, o_dhi, o_dlo} = dat_rdata;
  assign rst_slo = v6_r ? o_slo : {32'd0, o_slo[31:0] & MASK32};
  assign rst_dlo = v6_r ? o_dlo : {32'd0, o_dlo[31:0] & MASK32};
  assign lis_lo  = v6_r ? listen_addr_lo_r : {32'd0, listen_addr_lo_r[31:0]};

  // result register
  logic        valid_r, fwd_r;
  logic [2:0]  state_o_r;
  logic [15:0] osp_r, odp_r;
  logic [63:0] oshi_r, oslo_r, odhi_r, odlo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev) begin
      fwd_r     <= 1'b0;
      state_o_r <= '0;
      osp_r     <= '0;
      odp_r     <= '0;
      oshi_r    <= '0;
      oslo_r    <= '0;
      odhi_r    <= '0;
      odlo_r    <= '0;
      if (outb_r) begin
        state_o_r <= fwd ? nxt : cur;
        if (fwd) begin
          fwd_r <= 1'b1;
          if (local_r) begin
            osp_r  <= sport_r;
            odp_r  <= listen_port_r;
            oshi_r <= shi_r;
            oslo_r <= slo_r;
            odhi_r <= v6_r ? listen_addr_hi_r : '0;
            odlo_r <= lis_lo;
          end else begin
            osp_r  <= o_dport;
            odp_r  <= dport_r;
            oshi_r <= v6_r ? o_dhi : '0;
            oslo_r <= rst_dlo;
            odhi_r <= v6_r ? o_shi : '0;
            odlo_r <= rst_slo;
          end
        end
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_forward     = fwd_r;
  assign out_new_state   = state_o_r;
  assign out_src_port    = osp_r;
  assign out_dst_port    = odp_r;
  assign out_src_addr_hi = oshi_r;
  assign out_src_addr_lo = oslo_r;
  assign out_dst_addr_hi = odhi_r;
  assign out_dst_addr_lo = odlo_r;

endmodule
`default_nettype wire

### src/tcp_port_redirect_conntrack.sv
// TCP connection tracker with redirect to a local proxy listener. A header is
// taken when start is high and busy is low; it passes the quotient, remainder
// and evaluate states and its result is registered onto the out_ ports for
// exactly one cycle, marked by out_valid; the receiver cannot stall it. The
// next header may be taken in the cycle its result is shown. The idle state
// captures the header, the quotient state multiplies the port by the
// reciprocal, the remainder state takes the remainder as table index and reads
// the port-indexed tables, the evaluate state updates the entry and forms the
// result. After reset the block clears the state table, one entry per cycle,
// and holds busy high until the sweep ends; configuration writes are taken at
// any time and must only be made while no transaction is in flight.
`default_nettype none
module tcp_port_redirect_conntrack
  import tprc_pkg::*;
#(
  parameter int unsigned PORT_ENTRIES = PORT_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_outbound,
  input  wire logic        in_is_ipv6,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic        in_flag_syn,
  input  wire logic        in_flag_ack,
  input  wire logic        in_flag_fin,
  input  wire logic        in_flag_rst,
  input  wire logic [63:0] in_src_addr_hi,
  input  wire logic [63:0] in_src_addr_lo,
  input  wire logic [63:0] in_dst_addr_hi,
  input  wire logic [63:0] in_dst_addr_lo,
  output logic             out_valid,
  output logic             out_forward,
  output logic [2:0]       out_new_state,
  output logic [15:0]      out_src_port,
  output logic [15:0]      out_dst_port,
  output logic [63:0]      out_src_addr_hi,
  output logic [63:0]      out_src_addr_lo,
  output logic [63:0]      out_dst_addr_hi,
  output logic [63:0]      out_dst_addr_lo
);

  tprc_cmd_t  cmd;
  tprc_stat_t stat;

  // controller
  tprc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath
  tprc_dp #(.PORT_ENTRIES(PORT_ENTRIES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_outbound     (in_outbound),
    .in_is_ipv6      (in_is_ipv6),
    .in_src_port     (in_src_port),
    .in_dst_port     (in_dst_port),
    .in_flag_syn     (in_flag_syn),
    .in_flag_ack     (in_flag_ack),
    .in_flag_fin     (in_flag_fin),
    .in_flag_rst     (in_flag_rst),
    .in_src_addr_hi  (in_src_addr_hi),
    .in_src_addr_lo  (in_src_addr_lo),
    .in_dst_addr_hi  (in_dst_addr_hi),
    .in_dst_addr_lo  (in_dst_addr_lo),
    .out_valid       (out_valid),
    .out_forward     (out_forward),
    .out_new_state   (out_new_state),
    .out_src_port    (out_src_port),
    .out_dst_port    (out_dst_port),
    .out_src_addr_hi (out_src_addr_hi),
    .out_src_addr_lo (out_src_addr_lo),
    .out_dst_addr_hi (out_dst_addr_hi),
    .out_dst_addr_lo (out_dst_addr_lo)
  );

  // every accepted transaction yields its result after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result missing after accepted transaction");

  // a result is only shown while the block is free again
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // a dropped packet carries no header words
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_forward) |-> (out_src_port == 16'd0 && out_dst_port == 16'd0))
    else $error("dropped packet with non-zero ports");

  // no new transaction is taken while the sweep or an item is running
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block free right after accepting a transaction");

endmodule
`default_nettype wire
